[rtl/axa2e_pkg.sv]
// Types, constants and fixed-point helpers for the axis-angle to Euler converter.
`timescale 1ns / 1ps
package axa2e_pkg;

    // Width of the multiplier operands, Q.28.
    localparam int QW = 36;
    // Width of the CORDIC datapath, Q.28.
    localparam int CW = 40;

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [CW-1:0] t_c;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] rot_angle;
    } t_in;

    typedef struct packed {
        logic signed [15:0] euler_first;
        logic signed [15:0] euler_second;
        logic signed [15:0] euler_third;
        logic [1:0]         pole_case;
    } t_out;

    localparam logic [1:0] POLE_NONE  = 2'd0;
    localparam logic [1:0] POLE_NORTH = 2'd1;
    localparam logic [1:0] POLE_SOUTH = 2'd2;

    localparam t_c QONE    = 40'sd268435456;
    localparam t_c QPI     = 40'sd843314857;
    localparam t_c QHALFPI = 40'sd421657428;
    localparam t_c QGAIN   = 40'sd163008218;
    localparam t_q QPOLE   = 36'sd267898585;
    localparam t_c OUT_PI  = 40'sd25736;
    localparam logic signed [15:0] OUT_HALFPI = 16'sd12868;

    // atan(2^-i) in Q.28.
    localparam t_c ATAN [24] = '{
        40'sd210828714, 40'sd124459457, 40'sd65760959, 40'sd33381290,
        40'sd16755422,  40'sd8385879,   40'sd4193963,  40'sd2097109,
        40'sd1048571,   40'sd524287,    40'sd262144,   40'sd131072,
        40'sd65536,     40'sd32768,     40'sd16384,    40'sd8192,
        40'sd4096,      40'sd2048,      40'sd1024,     40'sd512,
        40'sd256,       40'sd128,       40'sd64,       40'sd32
    };

    // Q.28 product, rounded toward minus infinity.
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [2*QW-1:0] p;
        begin
            p = a * b;
            return p[QW+27:28];
        end
    endfunction

    // Q.28 to Q3.13 with round half up and saturation to plus or minus pi.
    function automatic logic signed [15:0] to_out(input t_c v);
        t_c r;
        begin
            r = (v + t_c'(16384)) >>> 15;
            if (r > OUT_PI) begin
                r = OUT_PI;
            end else if (r < -OUT_PI) begin
                r = -OUT_PI;
            end
            return r[15:0];
        end
    endfunction

endpackage

[rtl/axis_angle_to_euler.sv]
// Pipelined conversion of a rotation axis and angle into three Euler angles.
`timescale 1ns / 1ps
//
// Input channel: i_valid / o_stall carry one axis (Q1.14) and angle (Q3.13)
// per transfer. Output channel: o_valid / i_stall carry the three angles in
// Q3.13 radians and the pole code (0 regular, 1 north, 2 south).
// One item per cycle is accepted while o_stall is low; there is no state
// between items. The pipeline is made of the two CORDIC chains (sine/cosine,
// then arctangent), three multiply stages, a 29-stage square root (one bit
// per stage) and the input, fold, root seed, vectoring seed and output
// registers.
// The whole pipeline advances together while the output register is empty or
// being taken. When the receiver stalls with a result waiting, every stage
// holds and o_stall rises in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits; the block can accept an item as soon as reset
// is released.
module axis_angle_to_euler #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  axa2e_pkg::t_in    i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output axa2e_pkg::t_out   o_data
);
    import axa2e_pkg::*;

    localparam int N  = CORDIC_STAGES;
    localparam int NR = 29;
    localparam int L  = 2 * N + 37;

    typedef struct packed {
        t_c xf, yf, af;
        t_c xh, yh, ah;
        logic ff, fh;
        logic signed [15:0] ax, ay, az;
    } t_sc;

    typedef struct packed {
        t_q t, xy, zs, ys, xz, xs, yz, yy, zz, xx, xhs, hc;
    } t_p1;

    typedef struct packed {
        t_q test, xzt, yzt, syy, sxx, ys, xs, xhs, hc, t;
    } t_p2;

    typedef struct packed {
        t_q y1, x1, y2, x2, tt, test, xhs, hc;
        logic north, south;
    } t_p3;

    typedef struct packed {
        logic [56:0] rem;
        logic [57:0] res;
        t_q y1, x1, y2, x2, test;
        logic [1:0] pole;
    } t_sq;

    typedef struct packed {
        t_c x, y, z;
        logic zero;
    } t_cv;

    typedef struct packed {
        t_cv u1, u2, u3;
        logic [1:0] pole;
    } t_at;

    function automatic t_cv cv_fold(input t_c y, input t_c x);
        t_cv r;
        begin
            r.zero = (x == '0) && (y == '0);
            r.x = x;
            r.y = y;
            r.z = '0;
            if (x < 0) begin
                r.z = (y >= 0) ? QPI : -QPI;
                r.x = -x;
                r.y = -y;
            end
            return r;
        end
    endfunction

    function automatic t_cv cv_step(input t_cv v, input int i);
        t_cv r;
        begin
            r.zero = v.zero;
            if (v.y > 0) begin
                r.x = v.x + (v.y >>> i);
                r.y = v.y - (v.x >>> i);
                r.z = v.z + ATAN[i];
            end else begin
                r.x = v.x - (v.y >>> i);
                r.y = v.y + (v.x >>> i);
                r.z = v.z - ATAN[i];
            end
            return r;
        end
    endfunction

    logic          en;
    logic [L-1:0]  r_vld;
    t_in           r_in;
    t_sc           r_sc [N+1];
    t_p1           r_p1;
    t_p2           r_p2;
    t_p3           r_p3;
    t_sq           r_sq [NR+1];
    t_at           r_at [N+1];
    t_out          r_out;

    assign en      = !r_vld[L-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[L-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_data;
        end
    end

    // Fold both sine/cosine arguments into plus or minus pi/2.
    t_sc n_sc0;
    always_comb begin
        n_sc0.af = t_c'(r_in.rot_angle) <<< 15;
        n_sc0.ah = t_c'(r_in.rot_angle) <<< 14;
        n_sc0.ff = 1'b0;
        n_sc0.fh = 1'b0;
        if (n_sc0.af > QHALFPI) begin
            n_sc0.af = n_sc0.af - QPI;
            n_sc0.ff = 1'b1;
        end else if (n_sc0.af < -QHALFPI) begin
            n_sc0.af = n_sc0.af + QPI;
            n_sc0.ff = 1'b1;
        end
        if (n_sc0.ah > QHALFPI) begin
            n_sc0.ah = n_sc0.ah - QPI;
            n_sc0.fh = 1'b1;
        end else if (n_sc0.ah < -QHALFPI) begin
            n_sc0.ah = n_sc0.ah + QPI;
            n_sc0.fh = 1'b1;
        end
        n_sc0.xf = QGAIN;
        n_sc0.yf = '0;
        n_sc0.xh = QGAIN;
        n_sc0.yh = '0;
        n_sc0.ax = r_in.axis_x;
        n_sc0.ay = r_in.axis_y;
        n_sc0.az = r_in.axis_z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sc[0] <= n_sc0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_sc
        t_sc n_sc;
        always_comb begin
            n_sc = r_sc[i];
            if (r_sc[i].af >= 0) begin
                n_sc.xf = r_sc[i].xf - (r_sc[i].yf >>> i);
                n_sc.yf = r_sc[i].yf + (r_sc[i].xf >>> i);
                n_sc.af = r_sc[i].af - ATAN[i];
            end else begin
                n_sc.xf = r_sc[i].xf + (r_sc[i].yf >>> i);
                n_sc.yf = r_sc[i].yf - (r_sc[i].xf >>> i);
                n_sc.af = r_sc[i].af + ATAN[i];
            end
            if (r_sc[i].ah >= 0) begin
                n_sc.xh = r_sc[i].xh - (r_sc[i].yh >>> i);
                n_sc.yh = r_sc[i].yh + (r_sc[i].xh >>> i);
                n_sc.ah = r_sc[i].ah - ATAN[i];
            end else begin
                n_sc.xh = r_sc[i].xh + (r_sc[i].yh >>> i);
                n_sc.yh = r_sc[i].yh - (r_sc[i].xh >>> i);
                n_sc.ah = r_sc[i].ah + ATAN[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sc[i+1] <= n_sc;
            end
        end
    end

    // First products: undo the argument fold, scale the axis to Q.28.
    t_p1 n_p1;
    t_q  s_s, s_c, s_hs, s_hc, s_x, s_y, s_z;
    always_comb begin
        s_s  = t_q'(r_sc[N].ff ? -r_sc[N].yf : r_sc[N].yf);
        s_c  = t_q'(r_sc[N].ff ? -r_sc[N].xf : r_sc[N].xf);
        s_hs = t_q'(r_sc[N].fh ? -r_sc[N].yh : r_sc[N].yh);
        s_hc = t_q'(r_sc[N].fh ? -r_sc[N].xh : r_sc[N].xh);
        s_x  = t_q'(r_sc[N].ax) <<< 14;
        s_y  = t_q'(r_sc[N].ay) <<< 14;
        s_z  = t_q'(r_sc[N].az) <<< 14;
        n_p1.t   = t_q'(QONE) - s_c;
        n_p1.xy  = qmul(s_x, s_y);
        n_p1.zs  = qmul(s_z, s_s);
        n_p1.ys  = qmul(s_y, s_s);
        n_p1.xz  = qmul(s_x, s_z);
        n_p1.xs  = qmul(s_x, s_s);
        n_p1.yz  = qmul(s_y, s_z);
        n_p1.yy  = qmul(s_y, s_y);
        n_p1.zz  = qmul(s_z, s_z);
        n_p1.xx  = qmul(s_x, s_x);
        n_p1.xhs = qmul(s_x, s_hs);
        n_p1.hc  = s_hc;
    end

    t_p2 n_p2;
    always_comb begin
        n_p2.test = qmul(r_p1.xy, r_p1.t) + r_p1.zs;
        n_p2.xzt  = qmul(r_p1.xz, r_p1.t);
        n_p2.yzt  = qmul(r_p1.yz, r_p1.t);
        n_p2.syy  = r_p1.yy + r_p1.zz;
        n_p2.sxx  = r_p1.xx + r_p1.zz;
        n_p2.ys   = r_p1.ys;
        n_p2.xs   = r_p1.xs;
        n_p2.xhs  = r_p1.xhs;
        n_p2.hc   = r_p1.hc;
        n_p2.t    = r_p1.t;
    end

    t_p3 n_p3;
    always_comb begin
        n_p3.y1    = r_p2.ys - r_p2.xzt;
        n_p3.x1    = t_q'(QONE) - qmul(r_p2.syy, r_p2.t);
        n_p3.y2    = r_p2.xs - r_p2.yzt;
        n_p3.x2    = t_q'(QONE) - qmul(r_p2.sxx, r_p2.t);
        n_p3.tt    = qmul(r_p2.test, r_p2.test);
        n_p3.test  = r_p2.test;
        n_p3.xhs   = r_p2.xhs;
        n_p3.hc    = r_p2.hc;
        n_p3.north = r_p2.test > QPOLE;
        n_p3.south = r_p2.test < -QPOLE;
    end

    // Pick the arctangent operands and seed the square root of 1 - test^2.
    t_sq n_sq0;
    t_q  s_d;
    always_comb begin
        s_d = t_q'(QONE) - r_p3.tt;
        if (s_d < 0) begin
            s_d = '0;
        end
        n_sq0.rem  = {s_d[28:0], 28'd0};
        n_sq0.res  = '0;
        n_sq0.y2   = r_p3.y2;
        n_sq0.x2   = r_p3.x2;
        n_sq0.test = r_p3.test;
        if (r_p3.north || r_p3.south) begin
            n_sq0.y1 = r_p3.xhs;
            n_sq0.x1 = r_p3.hc;
        end else begin
            n_sq0.y1 = r_p3.y1;
            n_sq0.x1 = r_p3.x1;
        end
        if (r_p3.north) begin
            n_sq0.pole = POLE_NORTH;
        end else if (r_p3.south) begin
            n_sq0.pole = POLE_SOUTH;
        end else begin
            n_sq0.pole = POLE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_sq[0] <= n_sq0;
        end
    end

    // Floor square root, one result bit per stage.
    for (genvar k = 0; k < NR; k++) begin : g_sq
        localparam logic [57:0] BIT = 58'd1 << (56 - 2 * k);
        t_sq         n_sq;
        logic [57:0] s_trial;
        always_comb begin
            n_sq    = r_sq[k];
            s_trial = r_sq[k].res + BIT;
            if ({1'b0, r_sq[k].rem} >= s_trial) begin
                n_sq.rem = r_sq[k].rem - s_trial[56:0];
                n_sq.res = (r_sq[k].res >> 1) + BIT;
            end else begin
                n_sq.res = r_sq[k].res >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k+1] <= n_sq;
            end
        end
    end

    t_at n_at0;
    always_comb begin
        n_at0.u1   = cv_fold(t_c'(r_sq[NR].y1), t_c'(r_sq[NR].x1));
        n_at0.u2   = cv_fold(t_c'(r_sq[NR].y2), t_c'(r_sq[NR].x2));
        n_at0.u3   = cv_fold(t_c'(r_sq[NR].test), t_c'({1'b0, r_sq[NR].res[28:0]}));
        n_at0.pole = r_sq[NR].pole;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_at[0] <= n_at0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_at
        t_at n_at;
        always_comb begin
            n_at.u1   = cv_step(r_at[i].u1, i);
            n_at.u2   = cv_step(r_at[i].u2, i);
            n_at.u3   = cv_step(r_at[i].u3, i);
            n_at.pole = r_at[i].pole;
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_at[i+1] <= n_at;
            end
        end
    end

    t_out n_out;
    t_c   s_a1, s_a2, s_a3;
    always_comb begin
        s_a1 = r_at[N].u1.zero ? '0 : r_at[N].u1.z;
        s_a2 = r_at[N].u2.zero ? '0 : r_at[N].u2.z;
        s_a3 = r_at[N].u3.zero ? '0 : r_at[N].u3.z;
        n_out.pole_case = r_at[N].pole;
        case (r_at[N].pole)
            POLE_NORTH: begin
                n_out.euler_first  = to_out(s_a1 <<< 1);
                n_out.euler_second = OUT_HALFPI;
                n_out.euler_third  = '0;
            end
            POLE_SOUTH: begin
                n_out.euler_first  = to_out(-(s_a1 <<< 1));
                n_out.euler_second = -OUT_HALFPI;
                n_out.euler_third  = '0;
            end
            default: begin
                n_out.euler_first  = to_out(s_a1);
                n_out.euler_second = to_out(-s_a2);
                n_out.euler_third  = to_out(s_a3);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule
